### sv/agce_pkg.sv
// agce_pkg: shared types and constants of the grid cell enumerator
// used by agce_ctrl, agce_dp and aabb_grid_cell_enumerator; no dependencies
package agce_pkg;

  localparam int COORD_W    = 48;
  localparam int CELL_W     = 32;
  localparam int GRID_W     = 16;
  localparam int IDX_W      = 3;   // cell offset within one axis, spans of up to 8 cells
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int OUT_DATA_W = 2 * CELL_W;

  localparam logic [GRID_W-1:0] GRID_RESET = 16'd16;

  // which box bound the shared divider works on
  typedef enum logic [1:0] {
    SEL_MIN_X = 2'd0,
    SEL_MAX_X = 2'd1,
    SEL_MIN_Z = 2'd2,
    SEL_MAX_Z = 2'd3
  } sel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             load;       // latch the box on an input transaction
    logic             div_step;   // run two quotient bits
    logic             div_first;  // first step, start from the selected bound
    logic             div_save;   // final step, store the cell index
    sel_t             sel;
    logic             out_load;   // capture a result into the output register
    logic             big;
    logic             last;
    logic [IDX_W-1:0] xi;
    logic [IDX_W-1:0] zi;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic             box_ok;     // incoming box is non-empty on all axes
    logic             too_big;    // span exceeds the limit on X or Z
    logic [IDX_W-1:0] nx_m1;      // X cell count minus one
    logic [IDX_W-1:0] nz_m1;      // Z cell count minus one
    logic             out_free;   // output register can take a result
  } sts_t;

endpackage

### sv/aabb_grid_cell_enumerator.sv
// aabb_grid_cell_enumerator: lists the X-Z grid cells covered by a box, X outer, Z inner.
// Four divisions of the box bounds by the grid size run on one shared divider; the first
// result follows the last division step, then one cell per cycle while the output is free.
// Up to MAX_SPAN**2 results per box; a new box is taken only after the last result of the
// previous one is loaded, an empty box is dropped in idle. Reset (rst_n, synchronous):
// grid_size to 16, sequencer idle, output register empty. Depends on agce_pkg, agce_ctrl, agce_dp
module aabb_grid_cell_enumerator #(
  parameter int MAX_SPAN  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: grid_size
  input  logic                            cfg_tvalid,
  output logic                            cfg_tready,
  input  logic [agce_pkg::GRID_W-1:0]     cfg_tdata,   // grid_size[15:0]
  // box input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [agce_pkg::IN_DATA_W-1:0]  in_tdata,    // min_x, min_y, min_z, max_x, max_y, max_z
  // cell output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [agce_pkg::OUT_DATA_W-1:0] out_tdata,   // cell_x[31:0], cell_z[63:32]
  output logic                            out_tuser,   // too_large
  output logic                            out_tlast    // last
);

  localparam int STEPS = (agce_pkg::COORD_W - FRAC_BITS) / 2;

  agce_pkg::cmd_t cmd;
  agce_pkg::sts_t sts;

  assign cfg_tready = 1'b1;

  // sequencer
  agce_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and result register
  agce_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_SPAN  (MAX_SPAN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_tvalid),
    .cfg_data  (cfg_tdata),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_big   (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

### sv/agce_ctrl.sv
// agce_ctrl: sequencer for box load, four cell index divisions and cell emission
// depends on agce_pkg for the command and status structs
module agce_ctrl #(
  parameter int STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  agce_pkg::sts_t sts,
  output agce_pkg::cmd_t cmd
);

  localparam int CW = $clog2(STEPS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  agce_pkg::sel_t              sel_r, sel_nxt;
  logic [agce_pkg::IDX_W-1:0]  xi_r, xi_nxt;
  logic [agce_pkg::IDX_W-1:0]  zi_r, zi_nxt;
  logic                        step_last;
  logic                        cell_last;

  assign step_last = (cnt_r == CW'(STEPS - 1));
  assign cell_last = (xi_r == sts.nx_m1) && (zi_r == sts.nz_m1);
  assign in_ready  = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    xi_nxt    = xi_r;
    zi_nxt    = zi_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    cmd.xi    = xi_r;
    cmd.zi    = zi_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.box_ok) begin
            state_nxt = S_DIV;
            cnt_nxt   = '0;
            sel_nxt   = agce_pkg::SEL_MIN_X;
          end
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cmd.div_save  = step_last;
        if (step_last) begin
          cnt_nxt = '0;
          if (sel_r == agce_pkg::SEL_MAX_Z) begin
            state_nxt = S_EMIT;
            xi_nxt    = '0;
            zi_nxt    = '0;
          end else begin
            sel_nxt = agce_pkg::sel_t'(sel_r + 2'd1);
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.big      = sts.too_big;
          cmd.last     = sts.too_big || cell_last;
          if (sts.too_big || cell_last) begin
            state_nxt = S_IDLE;
          end else if (zi_r == sts.nz_m1) begin
            zi_nxt = '0;
            xi_nxt = xi_r + agce_pkg::IDX_W'(1);
          end else begin
            zi_nxt = zi_r + agce_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= agce_pkg::SEL_MIN_X;
      xi_r    <= '0;
      zi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      xi_r    <= xi_nxt;
      zi_r    <= zi_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // cell offsets never run past the box extent while emitting
  a_offsets_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !sts.too_big) |-> (xi_r <= sts.nx_m1 && zi_r <= sts.nz_m1))
    else $error("cell offset beyond box extent");

  // the fourth division hands over to emission
  a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sel_r == agce_pkg::SEL_MAX_Z && step_last) |=> (state_r == S_EMIT))
    else $error("emission did not follow the last division");

  // the last result of a box returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.last) |=> (state_r == S_IDLE))
    else $error("sequencer not idle after last result");
`endif

endmodule

### sv/agce_dp.sv
// agce_dp: grid size register, box latch, shared radix-4 divider, cell index
// store, span check and output register; depends on agce_pkg
module agce_dp #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_SPAN  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [agce_pkg::GRID_W-1:0]        cfg_data,
  input  logic [agce_pkg::IN_DATA_W-1:0]     in_data,
  input  agce_pkg::cmd_t                     cmd,
  output agce_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [agce_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                               out_big,
  output logic                               out_last
);

  localparam int CW    = agce_pkg::COORD_W;
  localparam int GW    = agce_pkg::GRID_W;
  localparam int W     = CW - 1 - FRAC_BITS;   // magnitude bits above the fraction
  localparam int QW    = W + 1;                // signed cell index width
  localparam int STEPS = (W + 1) / 2;
  localparam int DW    = 2 * STEPS;

  logic [GW-1:0]          grid_r;
  logic [GW-1:0]          g_eff;
  logic [W-1:0]           dvd_r [4];
  logic [3:0]             neg_r;
  logic signed [QW-1:0]   q_r [4];
  logic [GW-1:0]          rem_r;
  logic [DW-1:0]          dq_r;
  logic [GW-1:0]          rem_src;
  logic [DW-1:0]          dq_src;
  logic [GW+1:0]          step_res;
  logic [DW-1:0]          dq_nxt;
  logic [W-1:0]           quo;
  logic signed [CW-1:0]   bound [4];
  logic [CW-1:0]          mag [4];
  logic signed [CW-1:0]   mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
  logic [QW:0]            dx, dz;
  logic                   big_x, big_z;
  logic                   out_valid_r;
  logic [agce_pkg::CELL_W-1:0] cx_r, cz_r;
  logic                   big_r, last_r;

  // two restoring division steps
  function automatic logic [GW+1:0] div2(logic [GW-1:0] rem, logic [1:0] bits,
                                         logic [GW-1:0] d);
    logic [GW:0]   t;
    logic [GW-1:0] r;
    logic          q1, q0;
    t = {rem, bits[1]};
    if (t >= {1'b0, d}) begin
      r  = GW'(t - {1'b0, d});
      q1 = 1'b1;
    end else begin
      r  = t[GW-1:0];
      q1 = 1'b0;
    end
    t = {r, bits[0]};
    if (t >= {1'b0, d}) begin
      r  = GW'(t - {1'b0, d});
      q0 = 1'b1;
    end else begin
      r  = t[GW-1:0];
      q0 = 1'b0;
    end
    return {r, q1, q0};
  endfunction

  // box fields and validity
  assign mn_x = in_data[0*CW +: CW];
  assign mn_y = in_data[1*CW +: CW];
  assign mn_z = in_data[2*CW +: CW];
  assign mx_x = in_data[3*CW +: CW];
  assign mx_y = in_data[4*CW +: CW];
  assign mx_z = in_data[5*CW +: CW];

  assign bound[agce_pkg::SEL_MIN_X] = mn_x;
  assign bound[agce_pkg::SEL_MAX_X] = mx_x - CW'(1);
  assign bound[agce_pkg::SEL_MIN_Z] = mn_z;
  assign bound[agce_pkg::SEL_MAX_Z] = mx_z - CW'(1);

  // floor of a negative value is the complement of the quotient of its complement
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = bound[i][CW-1] ? ~bound[i] : bound[i];
    end
  end

  assign g_eff = (grid_r == '0) ? GW'(1) : grid_r;

  // grid size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= agce_pkg::GRID_RESET;
    end else if (cfg_valid) begin
      grid_r <= cfg_data;
    end
  end

  // box latch, divisor scaling folded into a shift of the dividend
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        dvd_r[i] <= mag[i][CW-2:FRAC_BITS];
        neg_r[i] <= bound[i][CW-1];
      end
    end
  end

  // shared divider datapath
  assign rem_src  = cmd.div_first ? '0 : rem_r;
  assign dq_src   = cmd.div_first ? DW'(dvd_r[cmd.sel]) : dq_r;
  assign step_res = div2(rem_src, dq_src[DW-1:DW-2], g_eff);
  assign dq_nxt   = {dq_src[DW-3:0], step_res[1:0]};
  assign quo      = dq_nxt[W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      rem_r <= step_res[GW+1:2];
      dq_r  <= dq_nxt;
    end
    if (cmd.div_save) begin
      q_r[cmd.sel] <= neg_r[cmd.sel] ? ~{1'b0, quo} : {1'b0, quo};
    end
  end

  // span check
  assign dx    = (QW+1)'(q_r[agce_pkg::SEL_MAX_X]) - (QW+1)'(q_r[agce_pkg::SEL_MIN_X]);
  assign dz    = (QW+1)'(q_r[agce_pkg::SEL_MAX_Z]) - (QW+1)'(q_r[agce_pkg::SEL_MIN_Z]);
  assign big_x = (dx >= (QW+1)'(MAX_SPAN));
  assign big_z = (dz >= (QW+1)'(MAX_SPAN));

  assign sts.box_ok   = (mn_x < mx_x) && (mn_y < mx_y) && (mn_z < mx_z);
  assign sts.too_big  = big_x || big_z;
  assign sts.nx_m1    = dx[agce_pkg::IDX_W-1:0];
  assign sts.nz_m1    = dz[agce_pkg::IDX_W-1:0];
  assign sts.out_free = !out_valid_r || out_ready;

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      big_r  <= cmd.big;
      last_r <= cmd.last;
      if (cmd.big) begin
        cx_r <= '0;
        cz_r <= '0;
      end else begin
        cx_r <= agce_pkg::CELL_W'(q_r[agce_pkg::SEL_MIN_X]) + agce_pkg::CELL_W'(cmd.xi);
        cz_r <= agce_pkg::CELL_W'(q_r[agce_pkg::SEL_MIN_Z]) + agce_pkg::CELL_W'(cmd.zi);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {cz_r, cx_r};
  assign out_big   = big_r;
  assign out_last  = last_r;

`ifndef NO_ASSERTIONS
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // an oversized box gives one final result with cleared cell fields
  a_big_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && big_r) |-> (last_r && cx_r == '0 && cz_r == '0))
    else $error("oversized result malformed");
`endif

endmodule

### tb/sv/aabb_grid_cell_enumerator_tb.sv
// aabb_grid_cell_enumerator_tb: self-checking stream testbench of the grid cell enumerator
// a scoreboard class predicts the covered x-z cells per box; tasks drive the box and
// configuration channels, an initial block the result side; depends on agce_pkg and aabb_grid_cell_enumerator
module aabb_grid_cell_enumerator_tb;

  localparam int     COORD_W     = agce_pkg::COORD_W;
  localparam int     CELL_W      = agce_pkg::CELL_W;
  localparam int     GRID_W      = agce_pkg::GRID_W;
  localparam int     IN_DATA_W   = agce_pkg::IN_DATA_W;
  localparam int     OUT_DATA_W  = agce_pkg::OUT_DATA_W;
  localparam logic [GRID_W-1:0] GRID_RESET = agce_pkg::GRID_RESET;
  localparam int     FRAC        = 16;
  localparam int     SPAN_LIMIT  = 8;
  localparam longint COORD_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     SETTLE      = 80;
  localparam int     PHASE_ITEMS = 57;
  localparam int     HOLD_OFF    = 400;

  // box fields, min_x in the lowest bits as on in_tdata
  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } box_t;

  typedef struct {
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_z;
    logic                     too_large;
    logic                     last;
  } cell_t;

  // floor division for a positive divisor
  function automatic longint floor_div(longint v, longint d);
    longint q;
    q = v / d;
    if (v % d < 0) q = q - 1;
    return q;
  endfunction

  // predicts the covered cells of each accepted box and checks every result transaction
  class cover_checker;
    cell_t expected_cells[$];
    int    errors;
    int    grid;

    function new();
      errors = 0;
      grid   = int'(GRID_RESET);
    endfunction

    function void set_grid(logic [GRID_W-1:0] g);
      grid = (g == 0) ? 1 : int'(g);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // x outer, z inner, last on the final cell
    function void note_box(box_t b);
      longint mnx, mny, mnz, mxx, mxy, mxz;
      longint d, x0, x1, z0, z1;
      cell_t  c;
      mnx = longint'(b.min_x);
      mny = longint'(b.min_y);
      mnz = longint'(b.min_z);
      mxx = longint'(b.max_x);
      mxy = longint'(b.max_y);
      mxz = longint'(b.max_z);
      if (!(mnx < mxx) || !(mny < mxy) || !(mnz < mxz)) return;
      d  = longint'(grid) << FRAC;
      x0 = floor_div(mnx, d);
      x1 = floor_div(mxx - 1, d);
      z0 = floor_div(mnz, d);
      z1 = floor_div(mxz - 1, d);
      if (x1 - x0 + 1 > SPAN_LIMIT || z1 - z0 + 1 > SPAN_LIMIT) begin
        c.cell_x    = '0;
        c.cell_z    = '0;
        c.too_large = 1'b1;
        c.last      = 1'b1;
        expected_cells = {expected_cells, c};
        return;
      end
      for (longint x = x0; x <= x1; x++) begin
        for (longint z = z0; z <= z1; z++) begin
          c.cell_x    = x[CELL_W-1:0];
          c.cell_z    = z[CELL_W-1:0];
          c.too_large = 1'b0;
          c.last      = (x == x1 && z == z1);
          expected_cells = {expected_cells, c};
        end
      end
    endfunction

    task check_cell(cell_t got);
      cell_t exp_cell;
      if (expected_cells.size() == 0) begin
        report($sformatf("unexpected cell x=%0d z=%0d too_large=%0b last=%0b",
                         got.cell_x, got.cell_z, got.too_large, got.last));
        return;
      end
      exp_cell = expected_cells.pop_front();
      if (got.cell_x !== exp_cell.cell_x)
        report($sformatf("cell_x got %0d exp %0d", got.cell_x, exp_cell.cell_x));
      if (got.cell_z !== exp_cell.cell_z)
        report($sformatf("cell_z got %0d exp %0d", got.cell_z, exp_cell.cell_z));
      if (got.too_large !== exp_cell.too_large)
        report($sformatf("too_large got %0b exp %0b", got.too_large, exp_cell.too_large));
      if (got.last !== exp_cell.last)
        report($sformatf("last got %0b exp %0b", got.last, exp_cell.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_tvalid;
  logic                  cfg_tready;
  logic [GRID_W-1:0]     cfg_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  cover_checker sb = new();
  int           cycle_count = 0;
  bit           send_steady = 1'b0;
  bit           hold_off_req = 1'b0;
  longint       cell_len;

  aabb_grid_cell_enumerator #(
    .MAX_SPAN (SPAN_LIMIT),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata),   // grid_size[15:0]
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // min_x, min_y, min_z, max_x, max_y, max_z
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // cell_x[31:0], cell_z[63:32]
    .out_tuser (out_tuser),   // too_large
    .out_tlast (out_tlast)    // last
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("aabb_grid_cell_enumerator test failed");
      $finish;
    end
  end

  function automatic longint rand64();
    return longint'({$urandom, $urandom});
  endfunction

  function automatic box_t mk_box(longint lx, longint hx, longint ly, longint hy,
                                  longint lz, longint hz);
    box_t b;
    b.min_x = lx[COORD_W-1:0];
    b.max_x = hx[COORD_W-1:0];
    b.min_y = ly[COORD_W-1:0];
    b.max_y = hy[COORD_W-1:0];
    b.min_z = lz[COORD_W-1:0];
    b.max_z = hz[COORD_W-1:0];
    return b;
  endfunction

  // one axis covering up to ncell cells (ncell + 1 when unaligned), kept inside range
  function automatic void gen_axis(longint d, int ncell, bit aligned,
                                   output longint lo, output longint hi);
    logic signed [COORD_W-1:0] r48;
    longint                    w;
    r48 = COORD_W'(rand64());
    lo  = longint'(r48);
    if (aligned) begin
      lo = floor_div(lo, d) * d;
      if (lo < COORD_MIN) lo = lo + d;
      w = longint'(ncell) * d;
    end else begin
      w = 1 + longint'(longint'(unsigned'(rand64())) % unsigned'(longint'(ncell) * d));
    end
    hi = lo + w;
    if (hi > COORD_MAX) begin
      lo = lo - (hi - COORD_MAX);
      hi = COORD_MAX;
    end
  endfunction

  // mostly well-formed boxes, some oversized, empty and raw noise
  function automatic box_t rand_box(longint d);
    longint lx, hx, ly, hy, lz, hz, tmp;
    int     kind;
    int     ax;
    box_t   b;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
      return b;
    end
    gen_axis(d, $urandom_range(1, 7), $urandom_range(0, 3) == 0, lx, hx);
    gen_axis(d, $urandom_range(1, 7), $urandom_range(0, 3) == 0, lz, hz);
    gen_axis(longint'(1) << 24, $urandom_range(1, 1 << 16), 1'b0, ly, hy);
    if (kind >= 70 && kind < 80) begin
      // oversized on x, z or both
      ax = $urandom_range(0, 2);
      if (ax != 1) gen_axis(d, $urandom_range(8, 12), $urandom_range(0, 1) == 1, lx, hx);
      if (ax != 0) gen_axis(d, $urandom_range(8, 12), $urandom_range(0, 1) == 1, lz, hz);
    end else if (kind >= 80) begin
      // empty on one axis, either flat or inverted
      ax = $urandom_range(0, 2);
      if ($urandom_range(0, 1)) begin
        if (ax == 0) hx = lx;
        else if (ax == 1) hy = ly;
        else hz = lz;
      end else begin
        if (ax == 0) begin tmp = lx; lx = hx; hx = tmp; end
        else if (ax == 1) begin tmp = ly; ly = hy; hy = tmp; end
        else begin tmp = lz; lz = hz; hz = tmp; end
      end
    end
    return mk_box(lx, hx, ly, hy, lz, hz);
  endfunction

  function automatic int draw_gap();
    return send_steady ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic send_box(box_t b, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_box(b);
  endtask

  // stop offering boxes until every expected cell is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_grid(logic [GRID_W-1:0] g);
    @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= g;
    do @(posedge clk); while (!cfg_tready);
    sb.set_grid(g);
    cell_len = longint'(sb.grid) << FRAC;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int    stall;
    bit    sink_steady;
    int    taken;
    cell_t got;
    out_tready  = 1'b0;
    sink_steady = 1'b0;
    taken       = 0;
    forever begin
      if (hold_off_req) begin
        repeat (HOLD_OFF) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
        hold_off_req = 1'b0;
      end
      stall = sink_steady ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
      got.cell_x    = out_tdata[CELL_W-1:0];
      got.cell_z    = out_tdata[2*CELL_W-1:CELL_W];
      got.too_large = out_tuser;
      got.last      = out_tlast;
      sb.check_cell(got);
      taken++;
      if (taken % 50 == 0) sink_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // box and configuration side
  initial begin
    longint      dd;
    logic [15:0] grid_plan [6];
    rst_n      = 1'b0;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cell_len   = longint'(GRID_RESET) << FRAC;
    grid_plan  = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'($urandom_range(2, 65534)), 16'd16};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed boxes at the reset grid size
    dd = cell_len;
    send_box(mk_box(0, 1, 0, 1, 0, 1), 0);
    send_box(mk_box(-1, 0, -1, 0, -1, 0), 0);
    send_box(mk_box(0, 8 * dd, 0, 5, -8 * dd, 0), 1);
    send_box(mk_box(0, 9 * dd, 0, 5, 0, dd), 0);
    send_box(mk_box(0, dd, 0, 5, 0, 9 * dd), 2);
    send_box(mk_box(0, 8 * dd + 1, 0, 5, 0, dd), 0);
    send_box(mk_box(5, 5, 0, 1, 0, 1), 0);
    send_box(mk_box(0, 1, 5, 5, 0, 1), 0);
    send_box(mk_box(0, 1, 0, 1, 7, 3), 0);
    send_box(mk_box(3, -2, 9, 1, 7, 3), 3);
    send_box(mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX), 0);
    send_box(mk_box(COORD_MAX - 1, COORD_MAX, COORD_MAX - 1, COORD_MAX,
                    COORD_MAX - 1, COORD_MAX), 0);
    send_box(mk_box(COORD_MIN, COORD_MIN + 1, COORD_MIN, COORD_MIN + 1,
                    COORD_MIN, COORD_MIN + 1), 1);
    send_box(mk_box(dd - 1, dd + 1, 0, 1, 3 * dd, 3 * dd + 1), 0);
    send_box(mk_box(dd, 2 * dd, 0, 1, -dd, 0), 0);
    send_box(mk_box(-3 * dd - 5, -dd + 7, -100, 100, 2 * dd + 3, 4 * dd - 1), 0);
    send_box(mk_box(-4 * dd, 4 * dd, 0, 1, 0, 1), 4);
    send_box(mk_box(0, 1, 0, 1, -4 * dd, 4 * dd), 0);
    send_box(mk_box(COORD_MAX - 8 * dd, COORD_MAX, 0, 1, COORD_MIN, COORD_MIN + 8 * dd), 0);
    send_box(mk_box(COORD_MIN, COORD_MIN + 9 * dd, 0, 1, 0, 1), 5);

    // random phases; phase zero keeps the reset grid size, each later one writes the next planned size
    for (int p = 0; p <= 6; p++) begin
      if (p > 0) begin
        drain();
        write_grid(grid_plan[p-1]);
      end
      if (p == 1) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_steady = (p == 1 && i < 40) || (i % 60 < 12);
        if (p == 3 && i == 30) drain();
        send_box(rand_box(cell_len), draw_gap());
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("aabb_grid_cell_enumerator test passed");
    end else begin
      $display("aabb_grid_cell_enumerator test failed");
    end
    $finish;
  end

endmodule
